// ===== sv/rar_pkg.sv =====
// ----------------------------------------------------------------------------
// rar_pkg
// Shared constants and types for the rational arithmetic reduction block.
// ----------------------------------------------------------------------------
package rar_pkg;

  localparam int unsigned WIDTH_DEF = 32;

  // operation codes on the action field
  localparam logic [1:0] ACT_ADD = 2'd0;
  localparam logic [1:0] ACT_SUB = 2'd1;
  localparam logic [1:0] ACT_MUL = 2'd2;
  localparam logic [1:0] ACT_DIV = 2'd3;

  // result status codes
  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_ZDEN = 2'd1;
  localparam logic [1:0] STAT_OVFL = 2'd2;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_e;

endpackage

// ===== sv/rar_mul.sv =====
// ----------------------------------------------------------------------------
// rar_mul
// Unsigned magnitude multiplier; the product is registered by the caller.
// ----------------------------------------------------------------------------
module rar_mul #(
  parameter int unsigned WIDTH = rar_pkg::WIDTH_DEF
) (
  input  logic [WIDTH-1:0]   a_i,
  input  logic [WIDTH-1:0]   b_i,
  output logic [2*WIDTH-1:0] p_o
);

  assign p_o = (2*WIDTH)'(a_i) * (2*WIDTH)'(b_i);

endmodule

// ===== sv/rar_alu.sv =====
// ----------------------------------------------------------------------------
// rar_alu
// Shared add / subtract unit; on subtract the carry out means x >= y.
// ----------------------------------------------------------------------------
module rar_alu #(
  parameter int unsigned N = 2 * rar_pkg::WIDTH_DEF + 1
) (
  input  rar_pkg::alu_op_e op_i,
  input  logic [N-1:0]     x_i,
  input  logic [N-1:0]     y_i,
  output logic [N-1:0]     res_o,
  output logic             cout_o
);

  logic         sub;
  logic [N-1:0] y_op;
  logic [N:0]   sum;

  assign sub    = (op_i == rar_pkg::ALU_SUB);
  assign y_op   = sub ? ~y_i : y_i;
  assign sum    = {1'b0, x_i} + {1'b0, y_op} + {{N{1'b0}}, sub};
  assign res_o  = sum[N-1:0];
  assign cout_o = sum[N];

endmodule

// ===== sv/rational_arith_reduce.sv =====
// ----------------------------------------------------------------------------
// rational_arith_reduce
// Adds, subtracts (a minus b), multiplies or divides two fractions and returns
// the result reduced to lowest terms, sign on the numerator, denominator
// positive and 1 for a zero result. A zero denominator (also division by
// zero) gives status 1, a reduced result that does not fit gives status 2,
// both with zero fields. One item is worked on at a time: the raw terms come
// as two or three products from one shared WIDTH x WIDTH multiplier, then a
// shared 2*WIDTH+1 bit add/subtract unit runs a binary GCD (one shift or
// subtract per cycle) and two restoring divisions of the terms by the GCD.
// An item with a zero denominator skips the arithmetic. A new item is taken
// as soon as the previous one has moved into the output register.
// ----------------------------------------------------------------------------
module rational_arith_reduce #(
  parameter int unsigned WIDTH = rar_pkg::WIDTH_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [1:0]              action_i,
  input  logic signed [WIDTH-1:0] a_num_i,
  input  logic signed [WIDTH-1:0] a_den_i,
  input  logic signed [WIDTH-1:0] b_num_i,
  input  logic signed [WIDTH-1:0] b_den_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [WIDTH-1:0] res_num_o,
  output logic [WIDTH-2:0]        res_den_o,
  output logic [1:0]              status_o
);

  localparam int unsigned WD = 2 * WIDTH;
  localparam int unsigned CW = $clog2(WD);
  localparam logic [WD-1:0] LIM = WD'(1) << (WIDTH - 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL0,
    S_MUL1,
    S_MUL2,
    S_SUM,
    S_SUM2,
    S_GINIT,
    S_GCD,
    S_DIVN,
    S_DIVD,
    S_FIN
  } state_e;

  state_e state_q, state_d;

  logic [1:0]       act_q, act_d;
  logic [WIDTH-1:0] anm_q, anm_d, adm_q, adm_d, bnm_q, bnm_d, bdm_q, bdm_d;
  logic             nn_q, nn_d, dn_q, dn_d, s2_q, s2_d, zden_q, zden_d;
  logic [WD-1:0]    nm_q, nm_d, dm_q, dm_d, t2_q, t2_d;
  logic [WD-1:0]    ga_q, ga_d, gb_q, gb_d, rem_q, rem_d;
  logic [CW-1:0]    cnt_q, cnt_d;

  logic                    out_valid_q, out_valid_d;
  logic signed [WIDTH-1:0] res_num_q, res_num_d;
  logic [WIDTH-2:0]        res_den_q, res_den_d;
  logic [1:0]              status_q, status_d;

  // input magnitudes and signs
  logic [WIDTH-1:0] anm_in, adm_in, bnm_in, bdm_in;
  logic             ann_in, adn_in, bnn_in, bdn_in;

  always_comb begin
    ann_in = a_num_i[WIDTH-1];
    adn_in = a_den_i[WIDTH-1];
    bnn_in = b_num_i[WIDTH-1];
    bdn_in = b_den_i[WIDTH-1];
    anm_in = ann_in ? (~$unsigned(a_num_i) + WIDTH'(1)) : $unsigned(a_num_i);
    adm_in = adn_in ? (~$unsigned(a_den_i) + WIDTH'(1)) : $unsigned(a_den_i);
    bnm_in = bnn_in ? (~$unsigned(b_num_i) + WIDTH'(1)) : $unsigned(b_num_i);
    bdm_in = bdn_in ? (~$unsigned(b_den_i) + WIDTH'(1)) : $unsigned(b_den_i);
  end

  // shared multiplier, operands picked by step and operation
  logic [WIDTH-1:0] mul_a, mul_b;
  logic [WD-1:0]    prod;
  logic             addsub;

  assign addsub = (act_q == rar_pkg::ACT_ADD) || (act_q == rar_pkg::ACT_SUB);

  always_comb begin
    mul_a = adm_q;
    mul_b = bdm_q;
    unique case (state_q)
      S_MUL0: begin
        mul_a = anm_q;
        mul_b = (act_q == rar_pkg::ACT_MUL) ? bnm_q : bdm_q;
      end
      S_MUL1: begin
        if (addsub) begin
          mul_a = bnm_q;
          mul_b = adm_q;
        end else begin
          mul_a = adm_q;
          mul_b = (act_q == rar_pkg::ACT_MUL) ? bdm_q : bnm_q;
        end
      end
      default: begin
        mul_a = adm_q;
        mul_b = bdm_q;
      end
    endcase
  end

  rar_mul #(
    .WIDTH (WIDTH)
  ) u_mul (
    .a_i (mul_a),
    .b_i (mul_b),
    .p_o (prod)
  );

  // shared add / subtract unit
  rar_pkg::alu_op_e alu_op;
  logic [WD:0]      alu_x, alu_y, alu_res;
  logic             alu_ge;
  logic [WD-1:0]    dvd;

  assign dvd = (state_q == S_DIVN) ? nm_q : dm_q;

  always_comb begin
    alu_op = rar_pkg::ALU_SUB;
    alu_x  = '0;
    alu_y  = '0;
    unique case (state_q)
      S_SUM: begin
        alu_op = (nn_q == s2_q) ? rar_pkg::ALU_ADD : rar_pkg::ALU_SUB;
        alu_x  = {1'b0, nm_q};
        alu_y  = {1'b0, t2_q};
      end
      S_SUM2: begin
        alu_x = {1'b0, t2_q};
        alu_y = {1'b0, nm_q};
      end
      S_GCD: begin
        alu_x = {1'b0, ga_q};
        alu_y = {1'b0, gb_q};
      end
      S_DIVN, S_DIVD: begin
        alu_x = {rem_q, dvd[WD-1]};
        alu_y = {1'b0, gb_q};
      end
      default: begin
        alu_op = rar_pkg::ALU_SUB;
      end
    endcase
  end

  rar_alu #(
    .N (WD + 1)
  ) u_alu (
    .op_i   (alu_op),
    .x_i    (alu_x),
    .y_i    (alu_y),
    .res_o  (alu_res),
    .cout_o (alu_ge)
  );

  // final sign and range check
  logic             fin_neg, fit_num, fit_den;
  logic [WIDTH-1:0] fin_num;

  always_comb begin
    fin_neg = (nn_q ^ dn_q) && (nm_q != '0);
    fit_den = (dm_q[WD-1:WIDTH-1] == '0);
    fit_num = (nm_q[WD-1:WIDTH-1] == '0) || (fin_neg && (nm_q == LIM));
    fin_num = fin_neg ? (~nm_q[WIDTH-1:0] + WIDTH'(1)) : nm_q[WIDTH-1:0];
  end

  always_comb begin
    state_d     = state_q;
    act_d       = act_q;
    anm_d       = anm_q;
    adm_d       = adm_q;
    bnm_d       = bnm_q;
    bdm_d       = bdm_q;
    nn_d        = nn_q;
    dn_d        = dn_q;
    s2_d        = s2_q;
    zden_d      = zden_q;
    nm_d        = nm_q;
    dm_d        = dm_q;
    t2_d        = t2_q;
    ga_d        = ga_q;
    gb_d        = gb_q;
    rem_d       = rem_q;
    cnt_d       = cnt_q;
    res_num_d   = res_num_q;
    res_den_d   = res_den_q;
    status_d    = status_q;
    out_valid_d = out_valid_q && !out_ready_i;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          act_d  = action_i;
          anm_d  = anm_in;
          adm_d  = adm_in;
          bnm_d  = bnm_in;
          bdm_d  = bdm_in;
          nn_d   = (action_i == rar_pkg::ACT_MUL) ? (ann_in ^ bnn_in) : (ann_in ^ bdn_in);
          dn_d   = (action_i == rar_pkg::ACT_DIV) ? (adn_in ^ bnn_in) : (adn_in ^ bdn_in);
          s2_d   = bnn_in ^ adn_in ^ (action_i == rar_pkg::ACT_SUB);
          zden_d = (a_den_i == '0) || (b_den_i == '0) ||
                   ((action_i == rar_pkg::ACT_DIV) && (b_num_i == '0));
          state_d = zden_d ? S_FIN : S_MUL0;
        end
      end
      S_MUL0: begin
        nm_d    = prod;
        state_d = S_MUL1;
      end
      S_MUL1: begin
        if (addsub) begin
          t2_d    = prod;
          state_d = S_MUL2;
        end else begin
          dm_d    = prod;
          state_d = S_GINIT;
        end
      end
      S_MUL2: begin
        dm_d    = prod;
        state_d = S_SUM;
      end
      S_SUM: begin
        // unlike signs with a smaller first term take the reverse difference
        if ((nn_q == s2_q) || alu_ge) begin
          nm_d    = alu_res[WD-1:0];
          state_d = S_GINIT;
        end else begin
          state_d = S_SUM2;
        end
      end
      S_SUM2: begin
        nm_d    = alu_res[WD-1:0];
        nn_d    = s2_q;
        state_d = S_GINIT;
      end
      S_GINIT: begin
        ga_d    = nm_q;
        gb_d    = dm_q;
        state_d = S_GCD;
      end
      S_GCD: begin
        priority if (ga_q == '0) begin
          rem_d   = '0;
          cnt_d   = CW'(WD - 1);
          state_d = S_DIVN;
        end else if (!ga_q[0] && !gb_q[0]) begin
          // common factor of two comes out of the terms right away
          ga_d = ga_q >> 1;
          gb_d = gb_q >> 1;
          nm_d = nm_q >> 1;
          dm_d = dm_q >> 1;
        end else if (!ga_q[0]) begin
          ga_d = ga_q >> 1;
        end else if (!gb_q[0]) begin
          gb_d = gb_q >> 1;
        end else if (alu_ge) begin
          ga_d = alu_res[WD:1];
        end else begin
          ga_d = gb_q;
          gb_d = ga_q;
        end
      end
      S_DIVN, S_DIVD: begin
        rem_d = alu_ge ? alu_res[WD-1:0] : alu_x[WD-1:0];
        if (state_q == S_DIVN) begin
          nm_d = {nm_q[WD-2:0], alu_ge};
        end else begin
          dm_d = {dm_q[WD-2:0], alu_ge};
        end
        cnt_d = cnt_q - CW'(1);
        if (cnt_q == '0) begin
          rem_d   = '0;
          cnt_d   = CW'(WD - 1);
          state_d = (state_q == S_DIVN) ? S_DIVD : S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          res_num_d   = '0;
          res_den_d   = '0;
          priority if (zden_q) begin
            status_d = rar_pkg::STAT_ZDEN;
          end else if (!(fit_num && fit_den)) begin
            status_d = rar_pkg::STAT_OVFL;
          end else begin
            status_d  = rar_pkg::STAT_OK;
            res_num_d = $signed(fin_num);
            res_den_d = dm_q[WIDTH-2:0];
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      res_num_q   <= '0;
      res_den_q   <= '0;
      status_q    <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      res_num_q   <= res_num_d;
      res_den_q   <= res_den_d;
      status_q    <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q     <= act_d;
    anm_q     <= anm_d;
    adm_q     <= adm_d;
    bnm_q     <= bnm_d;
    bdm_q     <= bdm_d;
    nn_q      <= nn_d;
    dn_q      <= dn_d;
    s2_q      <= s2_d;
    zden_q    <= zden_d;
    nm_q      <= nm_d;
    dm_q      <= dm_d;
    t2_q      <= t2_d;
    ga_q      <= ga_d;
    gb_q      <= gb_d;
    rem_q     <= rem_d;
    cnt_q     <= cnt_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign res_num_o   = res_num_q;
  assign res_den_o   = res_den_q;
  assign status_o    = status_q;

  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("sequencer took a second item while busy");

  a_ok_den_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == rar_pkg::STAT_OK) |-> (res_den_o != '0))
    else $error("good result with zero denominator");

  a_err_fields_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != rar_pkg::STAT_OK) |->
      (res_num_o == '0 && res_den_o == '0))
    else $error("error item with nonzero fields");

  a_zero_unit_den : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == rar_pkg::STAT_OK && res_num_o == '0) |->
      (res_den_o == (WIDTH-1)'(1)))
    else $error("zero result without unit denominator");

endmodule

// ===== sim/rational_arith_reduce_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_arith_reduce_tb
// Self-checking bench for the fraction add/sub/mul/div unit. A short directed
// set hits each operation, the zero denominator and divide-by-zero errors, zero
// results and the width limits, then random fractions run under several
// handshake idle/stall mixes. Each result is checked against a local
// sign-magnitude model with Euclidean reduction.
// ----------------------------------------------------------------------------
module rational_arith_reduce_tb;

  localparam int unsigned W           = rar_pkg::WIDTH_DEF;
  localparam int          CYCLE_LIMIT = 4_000_000;
  localparam int          DRAIN_CYC   = 600;
  localparam logic [31:0] INT_MAX     = 32'h7fff_ffff;
  localparam logic [31:0] INT_MIN     = 32'h8000_0000;
  localparam logic [31:0] MINUS_ONE   = 32'hffff_ffff;

  typedef struct packed {
    logic [31:0] num;
    logic [30:0] den;
    logic [1:0]  stat;
  } frac_res_t;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [1:0]        action;
  logic signed [31:0] a_num, a_den, b_num, b_den;
  logic              out_valid;
  logic              out_ready;
  logic signed [31:0] res_num;
  logic [30:0]       res_den;
  logic [1:0]        status;

  frac_res_t pending_q[$];
  int        idle_pct;
  int        stall_pct;
  int        mismatches;
  int        results_seen;
  int        items_sent;
  int        cycles;
  int        stat_cnt[3];
  int        op_cnt[4];

  rational_arith_reduce #(
    .WIDTH(W)
  ) u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .action_i   (action),
    .a_num_i    (a_num),
    .a_den_i    (a_den),
    .b_num_i    (b_num),
    .b_den_i    (b_den),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .res_num_o  (res_num),
    .res_den_o  (res_den),
    .status_o   (status)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_q.size());
      $display("** rational_arith_reduce: FAILED **");
      $finish;
    end
  end

  // receiver back-pressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  function automatic bit [63:0] mag32(input logic [31:0] v);
    return v[31] ? (64'h1_0000_0000 - {32'h0, v}) : {32'h0, v};
  endfunction

  // exact fraction arithmetic, reduced to lowest terms
  function automatic frac_res_t calc_fraction(input logic [1:0] act,
                                              input logic [31:0] an, ad, bn, bd);
    bit [63:0] anm, adm, bnm, bdm, pm, qm, nm, dm, x, y, t;
    bit        pn, qn, nn, dn, neg;
    frac_res_t r;
    anm = mag32(an);
    adm = mag32(ad);
    bnm = mag32(bn);
    bdm = mag32(bd);
    r = '0;
    if (adm == 0 || bdm == 0 || (act == rar_pkg::ACT_DIV && bnm == 0)) begin
      r.stat = rar_pkg::STAT_ZDEN;
      return r;
    end
    dm = adm * bdm;
    dn = ad[31] ^ bd[31];
    case (act)
      rar_pkg::ACT_ADD, rar_pkg::ACT_SUB: begin
        pm = anm * bdm;
        pn = an[31] ^ bd[31];
        qm = bnm * adm;
        qn = bn[31] ^ ad[31] ^ (act == rar_pkg::ACT_SUB);
        if (pn == qn) begin
          nm = pm + qm;
          nn = pn;
        end else if (pm >= qm) begin
          nm = pm - qm;
          nn = pn;
        end else begin
          nm = qm - pm;
          nn = qn;
        end
      end
      rar_pkg::ACT_MUL: begin
        nm = anm * bnm;
        nn = an[31] ^ bn[31];
      end
      default: begin
        nm = anm * bdm;
        nn = an[31] ^ bd[31];
        dm = adm * bnm;
        dn = ad[31] ^ bn[31];
      end
    endcase
    x = nm;
    y = dm;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    nm = nm / x;
    dm = dm / x;
    neg = nn ^ dn;
    if (nm == 0) begin
      neg = 1'b0;
      dm = 1;
    end
    if ((neg ? (nm > 64'h8000_0000) : (nm >= 64'h8000_0000)) || dm >= 64'h8000_0000) begin
      r.stat = rar_pkg::STAT_OVFL;
      return r;
    end
    t = neg ? (64'd0 - nm) : nm;
    r.num  = t[31:0];
    r.den  = dm[30:0];
    r.stat = rar_pkg::STAT_OK;
    return r;
  endfunction

  task automatic send_item(input logic [1:0] act, input logic [31:0] an, ad, bn, bd);
    frac_res_t want;
    want = calc_fraction(act, an, ad, bn, bd);
    pending_q.push_back(want);
    stat_cnt[want.stat]++;
    op_cnt[act]++;
    items_sent++;
    in_valid <= 1'b1;
    action   <= act;
    a_num    <= an;
    a_den    <= ad;
    b_num    <= bn;
    b_den    <= bd;
    do @(posedge clk); while (!in_ready);
    // optional sender gap after the handshake
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  always @(posedge clk) begin : result_check
    frac_res_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (pending_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result num=%0d den=%0d status=%0d",
                                  res_num, res_den, status));
      end else begin
        want = pending_q.pop_front();
        if (res_num !== want.num || res_den !== want.den || status !== want.stat)
          report_mismatch($sformatf(
            "item %0d: expected num=%0d den=%0d status=%0d, got num=%0d den=%0d status=%0d",
            results_seen, $signed(want.num), want.den, want.stat,
            res_num, res_den, status));
      end
    end
  end

  task automatic test_basic_ops();
    send_item(rar_pkg::ACT_ADD, 32'sd1, 32'sd2, 32'sd1, 32'sd3);
    send_item(rar_pkg::ACT_SUB, 32'sd1, 32'sd2, 32'sd1, 32'sd3);
    send_item(rar_pkg::ACT_MUL, -32'sd2, 32'sd3, 32'sd3, 32'sd4);
    send_item(rar_pkg::ACT_DIV, 32'sd1, 32'sd2, 32'sd1, -32'sd4);
    send_item(rar_pkg::ACT_SUB, 32'sd3, -32'sd7, -32'sd5, 32'sd2);
  endtask

  task automatic test_zero_den();
    send_item(rar_pkg::ACT_ADD, 32'sd5, 32'sd0, 32'sd1, 32'sd3);
    send_item(rar_pkg::ACT_MUL, 32'sd5, 32'sd7, 32'sd1, 32'sd0);
    send_item(rar_pkg::ACT_DIV, 32'sd5, 32'sd7, 32'sd0, 32'sd9);
    send_item(rar_pkg::ACT_DIV, INT_MIN, INT_MAX, 32'sd0, INT_MIN);
  endtask

  task automatic test_zero_result();
    send_item(rar_pkg::ACT_SUB, 32'sd3, 32'sd4, 32'sd6, 32'sd8);
    send_item(rar_pkg::ACT_MUL, 32'sd0, -32'sd5, 32'sd7, 32'sd3);
    send_item(rar_pkg::ACT_SUB, MINUS_ONE, MINUS_ONE, MINUS_ONE, MINUS_ONE);
    send_item(rar_pkg::ACT_DIV, 32'sd0, INT_MIN, -32'sd3, INT_MIN);
  endtask

  task automatic test_width_limits();
    send_item(rar_pkg::ACT_ADD, INT_MAX, 32'sd1, 32'sd1, 32'sd1);
    send_item(rar_pkg::ACT_MUL, INT_MIN, 32'sd1, 32'sd1, 32'sd1);
    send_item(rar_pkg::ACT_MUL, INT_MIN, 32'sd1, MINUS_ONE, 32'sd1);
    send_item(rar_pkg::ACT_MUL, 32'sd1, INT_MIN, 32'sd1, 32'sd1);
    send_item(rar_pkg::ACT_MUL, INT_MIN, INT_MIN, INT_MIN, INT_MIN);
    send_item(rar_pkg::ACT_ADD, INT_MAX, INT_MIN, INT_MIN, INT_MAX);
    send_item(rar_pkg::ACT_DIV, INT_MIN, INT_MAX, INT_MAX, INT_MIN);
    send_item(rar_pkg::ACT_ADD, INT_MIN, MINUS_ONE, 32'sd0, 32'sd1);
    send_item(rar_pkg::ACT_SUB, 32'sd1, INT_MAX, 32'sd1, INT_MAX - 1);
    send_item(rar_pkg::ACT_DIV, INT_MAX, INT_MAX, INT_MIN, INT_MIN);
  endtask

  function automatic logic [31:0] rand_operand(input bit tame);
    int unsigned sel;
    sel = tame ? $urandom_range(5) : $urandom_range(9);
    case (sel)
      0, 1, 2: return $urandom_range(32) - 16;
      3:       return $urandom_range(8000) - 4000;
      4:       return ($urandom_range(30) - 15) << $urandom_range(12);
      5: begin
        case ($urandom_range(7))
          0:       return 32'd0;
          1:       return 32'd1;
          2:       return MINUS_ONE;
          3:       return INT_MAX;
          4:       return INT_MIN;
          5:       return INT_MAX - 1;
          6:       return INT_MIN + 1;
          default: return 32'h0001_0000;
        endcase
      end
      default: return $urandom();
    endcase
  endfunction

  task automatic test_random(input int n, input int idle, input int stall);
    logic [31:0] an, ad, bn, bd, k;
    int unsigned mode;
    idle_pct  = idle;
    stall_pct = stall;
    repeat (n) begin
      mode = $urandom_range(99);
      an = rand_operand(mode < 65);
      ad = rand_operand(mode < 65);
      bn = rand_operand(mode < 65);
      bd = rand_operand(mode < 65);
      // b as a scaled copy of a: zero differences and unit quotients
      if (mode >= 90) begin
        k  = $urandom_range(18) - 9;
        bn = an * k;
        bd = ad * k;
      end
      send_item(2'($urandom_range(3)), an, ad, bn, bd);
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    action    = rar_pkg::ACT_ADD;
    a_num     = '0;
    a_den     = '0;
    b_num     = '0;
    b_den     = '0;
    out_ready = 1'b0;
    idle_pct  = 0;
    stall_pct = 0;
    mismatches   = 0;
    results_seen = 0;
    items_sent   = 0;
    cycles       = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_basic_ops();
    test_zero_den();
    test_zero_result();
    test_width_limits();
    test_random(470, 0, 0);
    test_random(470, 86, 0);
    test_random(470, 0, 86);
    test_random(490, 26, 26);

    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);

    $display("%0d items sent, %0d results checked in %0d cycles", items_sent,
             results_seen, cycles);
    $display("add %0d sub %0d mul %0d div %0d; ok %0d, zero den %0d, too wide %0d",
             op_cnt[rar_pkg::ACT_ADD], op_cnt[rar_pkg::ACT_SUB],
             op_cnt[rar_pkg::ACT_MUL], op_cnt[rar_pkg::ACT_DIV],
             stat_cnt[rar_pkg::STAT_OK], stat_cnt[rar_pkg::STAT_ZDEN],
             stat_cnt[rar_pkg::STAT_OVFL]);
    if (mismatches == 0 && pending_q.size() == 0) begin
      $display("** rational_arith_reduce: PASSED **");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("** rational_arith_reduce: FAILED **");
    end
    $finish;
  end

endmodule
